// ===== rtl/core/ccpe_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpe_pkg
// Shared types, constants and the direction lookup for the chain code encoder.
// ----------------------------------------------------------------------------
package ccpe_pkg;

  localparam logic [7:0] BIT_PAIR    = 8'h80;
  localparam logic [7:0] BIT_MARK    = 8'h40;
  localparam int         START_BYTES = 8;
  localparam int         BUF_BITS    = START_BYTES * 8;
  localparam int         CNT_W       = $clog2(START_BYTES + 1);

  // delta index: step of -1, 0, +1, or out of range
  localparam logic [1:0] D_NEG = 2'd0;
  localparam logic [1:0] D_ZER = 2'd1;
  localparam logic [1:0] D_POS = 2'd2;
  localparam logic [1:0] D_BAD = 2'd3;

  typedef struct packed {
    logic [BUF_BITS-1:0] data;
    logic [CNT_W-1:0]    len;
    logic                last;
    logic                bad;
  } burst_t;

  function automatic logic [1:0] delta_idx(input logic [31:0] d);
    logic [1:0] r;
    if (d == 32'hFFFF_FFFF) r = D_NEG;
    else if (d == 32'd0)    r = D_ZER;
    else if (d == 32'd1)    r = D_POS;
    else                    r = D_BAD;
    return r;
  endfunction

  // returns {ok, code}
  function automatic logic [3:0] step_lookup(input logic [1:0] ix, input logic [1:0] iy);
    logic [3:0] r;
    case ({ix, iy})
      {D_NEG, D_POS}: r = 4'b1_000;
      {D_ZER, D_POS}: r = 4'b1_001;
      {D_POS, D_POS}: r = 4'b1_010;
      {D_POS, D_ZER}: r = 4'b1_011;
      {D_POS, D_NEG}: r = 4'b1_100;
      {D_ZER, D_NEG}: r = 4'b1_101;
      {D_NEG, D_NEG}: r = 4'b1_110;
      {D_NEG, D_ZER}: r = 4'b1_111;
      default:        r = 4'b0_000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/ccpe_if.sv =====
// ----------------------------------------------------------------------------
// ccpe_if
// Valid/ready channels for path points and for the output byte stream.
// ----------------------------------------------------------------------------
interface ccpe_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic               final_point;

  modport source (output valid, x_coord, y_coord, final_point, input ready);
  modport sink   (input valid, x_coord, y_coord, final_point, output ready);
endinterface

interface ccpe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_path;
  logic       bad_step;

  modport source (output valid, out_byte, end_of_path, bad_step, input ready);
  modport sink   (input valid, out_byte, end_of_path, bad_step, output ready);
endinterface

// ===== rtl/core/ccpe_step.sv =====
// ----------------------------------------------------------------------------
// ccpe_step
// Input register, path state and step coding; builds at most one byte burst per point.
// ----------------------------------------------------------------------------
module ccpe_step (
  input  logic               clk,
  input  logic               rst,
  ccpe_point_if.sink         pts,
  input  logic               free,
  output logic               load,
  output ccpe_pkg::burst_t   burst
);

  logic        s1_valid;
  logic [31:0] s1_x;
  logic [31:0] s1_y;
  logic        s1_last;

  logic        in_path;
  logic [31:0] prev_x;
  logic [31:0] prev_y;
  logic        half_full;
  logic [2:0]  held_code;
  logic        held_bad;

  logic [3:0]  lut;
  logic [2:0]  code;
  logic        bad;
  logic        take;

  always_comb begin
    lut  = ccpe_pkg::step_lookup(ccpe_pkg::delta_idx(s1_x - prev_x),
                                 ccpe_pkg::delta_idx(s1_y - prev_y));
    code = lut[3] ? lut[2:0] : 3'd0;
    bad  = !lut[3];
  end

  always_comb begin
    burst = '0;
    if (!in_path) begin
      burst.data = {s1_y, s1_x};
      burst.len  = ccpe_pkg::CNT_W'(ccpe_pkg::START_BYTES);
      burst.last = s1_last;
      burst.bad  = 1'b0;
    end else if (half_full) begin
      burst.data[7:0] = ccpe_pkg::BIT_PAIR | ccpe_pkg::BIT_MARK |
                        {2'b00, code, held_code};
      burst.len  = ccpe_pkg::CNT_W'(1);
      burst.last = s1_last;
      burst.bad  = held_bad | bad;
    end else if (s1_last) begin
      burst.data[7:0] = ccpe_pkg::BIT_MARK | {5'b0, code};
      burst.len  = ccpe_pkg::CNT_W'(1);
      burst.last = 1'b1;
      burst.bad  = bad;
    end
  end

  assign take      = s1_valid && (burst.len == '0 || free);
  assign load      = take && burst.len != '0;
  assign pts.ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pts.ready) begin
      s1_valid <= pts.valid;
    end
    if (pts.valid && pts.ready) begin
      s1_x    <= pts.x_coord;
      s1_y    <= pts.y_coord;
      s1_last <= pts.final_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_path   <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      half_full <= 1'b0;
      held_code <= '0;
      held_bad  <= 1'b0;
    end else if (take) begin
      prev_x <= s1_x;
      prev_y <= s1_y;
      if (!in_path || half_full || s1_last) begin
        half_full <= 1'b0;
        held_code <= '0;
        held_bad  <= 1'b0;
      end else begin
        half_full <= 1'b1;
        held_code <= code;
        held_bad  <= bad;
      end
      in_path <= !s1_last;
    end
  end

endmodule

// ===== rtl/core/ccpe_emit.sv =====
// ----------------------------------------------------------------------------
// ccpe_emit
// Result buffer: holds a burst of up to eight bytes and shifts them out.
// ----------------------------------------------------------------------------
module ccpe_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ccpe_pkg::burst_t burst,
  output logic             free,
  ccpe_byte_if.source      stream
);

  logic [ccpe_pkg::BUF_BITS-1:0] data;
  logic [ccpe_pkg::CNT_W-1:0]    count;
  logic                          last;
  logic                          bad;
  logic                          pop;

  assign pop  = stream.valid && stream.ready;
  assign free = (count == '0) || (count == ccpe_pkg::CNT_W'(1) && pop);

  assign stream.valid       = count != '0;
  assign stream.out_byte    = data[7:0];
  assign stream.end_of_path = last && count == ccpe_pkg::CNT_W'(1);
  assign stream.bad_step    = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.len;
    end else if (pop) begin
      count <= count - ccpe_pkg::CNT_W'(1);
    end
    if (load) begin
      data <= burst.data;
      last <= burst.last;
      bad  <= burst.bad;
    end else if (pop) begin
      data <= data >> 8;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (count == '0 || (count == ccpe_pkg::CNT_W'(1) && pop)))
    else $error("burst loaded over pending bytes");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= ccpe_pkg::CNT_W'(ccpe_pkg::START_BYTES))
    else $error("byte count out of range");

  a_count_dec: assert property (@(posedge clk) disable iff (rst)
    (pop && !load) |=> count == $past(count) - ccpe_pkg::CNT_W'(1))
    else $error("byte count did not step down");

endmodule

// ===== rtl/core/chain_code_path_encoder_top.sv =====
// Path: a point is registered in the input stage of ccpe_step, and its burst is then
// loaded into the result buffer of ccpe_emit, which offers the first byte.
// Throughput: one point per cycle while each point yields at most one byte and the
// receiver is ready; a start point occupies the result buffer for 8 byte transfers.
// Reset (rst, synchronous): clears the input stage, path state and buffer.
// ----------------------------------------------------------------------------
// chain_code_path_encoder_top
// Eight-direction chain code encoder for a stream of path points.
// ----------------------------------------------------------------------------
module chain_code_path_encoder_top (
  input  logic        clk,
  input  logic        rst,
  ccpe_point_if.sink  pts,
  ccpe_byte_if.source stream
);

  logic             free;
  logic             load;
  ccpe_pkg::burst_t burst;

  ccpe_step u_step (
    .clk   (clk),
    .rst   (rst),
    .pts   (pts),
    .free  (free),
    .load  (load),
    .burst (burst)
  );

  ccpe_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .burst  (burst),
    .free   (free),
    .stream (stream)
  );

endmodule
